@@ design/spr_anim_pkg.sv @@
`default_nettype none

package spr_anim_pkg;

  // Input item commands
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_TIME    = 2'd2
  } cmd_e;

  // Register indexes (word address)
  typedef enum logic [1:0] {
    REG_GRID_COLS    = 2'd0,
    REG_GRID_ROWS    = 2'd1,
    REG_ANIM_LENGTH  = 2'd2,
    REG_FRAME_PERIOD = 2'd3
  } reg_idx_e;

  localparam int unsigned DIVISOR_W  = 16;
  localparam int unsigned SHORT_BITS = 8;
  localparam logic [4:0]  GRID_MAX   = 5'd16;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [4:0]  grid_cols;
    logic [4:0]  grid_rows;
    logic [6:0]  anim_length;
    logic [15:0] frame_period;
  } cfg_t;

  // Divider control and status
  typedef struct packed {
    logic start;
    logic short_op;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Grid size 0 acts as 1, above 16 acts as 16
  function automatic logic [4:0] clamp_grid(input logic [4:0] v);
    logic [4:0] r;
    if (v == 5'd0) begin
      r = 5'd1;
    end else if (v > GRID_MAX) begin
      r = GRID_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/spr_anim_regs.sv @@
`default_nettype none

module spr_anim_regs (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output spr_anim_pkg::cfg_t      cfg_o
);
  import spr_anim_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes on the access beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_cols    <= 5'd1;
      cfg_q.grid_rows    <= 5'd1;
      cfg_q.anim_length  <= 7'd1;
      cfg_q.frame_period <= 16'd1;
    end else if (wr_en) begin
      case (idx)
        REG_GRID_COLS:    cfg_q.grid_cols    <= pwdata[4:0];
        REG_GRID_ROWS:    cfg_q.grid_rows    <= pwdata[4:0];
        REG_ANIM_LENGTH:  cfg_q.anim_length  <= pwdata[6:0];
        REG_FRAME_PERIOD: cfg_q.frame_period <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_GRID_COLS:    prdata = 32'(cfg_q.grid_cols);
      REG_GRID_ROWS:    prdata = 32'(cfg_q.grid_rows);
      REG_ANIM_LENGTH:  prdata = 32'(cfg_q.anim_length);
      REG_FRAME_PERIOD: prdata = 32'(cfg_q.frame_period);
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/spr_anim_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle. A short operation
// divides the low 8 bits of the dividend in 8 steps.
module spr_anim_div #(
  parameter int unsigned DW = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire spr_anim_pkg::div_ctl_t  ctl_i,
  input  wire logic [DW-1:0]           dividend_i,
  input  wire logic [15:0]             divisor_i,
  output spr_anim_pkg::div_sts_t       sts_o,
  output logic [DW-1:0]                quot_o,
  output logic [15:0]                  rem_o
);
  import spr_anim_pkg::*;

  localparam int unsigned CNT_W       = $clog2(DW + 1);
  localparam int unsigned SHORT_SHIFT = DW - SHORT_BITS;

  logic [CNT_W-1:0]     cnt_q;
  logic                 done_q;
  logic [DW-1:0]        dvd_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W-1:0] dsr_q;

  logic [DIVISOR_W:0]   trial;
  logic                 ge;
  logic [DIVISOR_W-1:0] rem_nxt;

  // One restoring step
  assign trial   = {rem_q, dvd_q[DW-1]};
  assign ge      = trial >= {1'b0, dsr_q};
  assign rem_nxt = ge ? DIVISOR_W'(trial - {1'b0, dsr_q}) : trial[DIVISOR_W-1:0];

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (ctl_i.start) begin
      cnt_q  <= ctl_i.short_op ? CNT_W'(SHORT_BITS) : CNT_W'(DW);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Dividend shifts out at the top, quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      dvd_q <= ctl_i.short_op ? (dividend_i << SHORT_SHIFT) : dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[DW-2:0], ge};
      rem_q <= rem_nxt;
    end
  end

  assign sts_o.busy = (cnt_q != '0);
  assign sts_o.done = done_q;
  assign quot_o     = dvd_q;
  assign rem_o      = rem_q;

endmodule

`default_nettype wire

@@ design/sprite_animation_sequencer_core.sv @@
// One item at a time, paced by the shared one-bit-per-cycle divider: a new input beat is taken
// only once the result of the last one is registered.
// Reset clears play position, advance time and shown frame to 0 and the registers to 1;
// the frame table holds no reset value and needs no clearing pass.
`default_nettype none

module sprite_animation_sequencer_core #(
  parameter int unsigned MAX_FRAMES = 64,
  parameter int unsigned TIME_BITS  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [5:0]  entry_index_i,
  input  wire logic [7:0]  entry_frame_i,
  input  wire logic [31:0] current_time_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       shown_frame_o,
  output logic [3:0]       tile_col_o,
  output logic [3:0]       tile_row_o,
  output logic             advanced_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import spr_anim_pkg::*;

  localparam int unsigned PW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CW = (TIME_BITS > DIVISOR_W) ? TIME_BITS : DIVISOR_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CMP  = 8'b0000_0010,
    S_TDIV = 8'b0000_0100,
    S_POS  = 8'b0000_1000,
    S_RD   = 8'b0001_0000,
    S_TILE = 8'b0010_0000,
    S_COLS = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   go_q, go_d;

  cfg_t   cfg;

  logic [PW-1:0]        pos_q;
  logic [TIME_BITS-1:0] last_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] diff_q;
  logic [7:0]           cur_frame_q;
  logic                 adv_q;
  logic [7:0]           rd_data_q;
  logic [3:0]           col_q;
  logic [3:0]           row_q;

  logic                 out_valid_q;
  logic [7:0]           out_frame_q;
  logic [3:0]           out_col_q;
  logic [3:0]           out_row_q;
  logic                 out_adv_q;

  logic [7:0]           frame_table [MAX_FRAMES];

  logic                 in_acc;
  logic                 out_load;
  cmd_e                 cmd;

  logic [4:0]           cols_eff;
  logic [4:0]           rows_eff;
  logic [9:0]           tiles;
  logic [6:0]           len_eff;
  logic [15:0]          period_eff;
  logic [7:0]           pos_inc;

  div_ctl_t             div_ctl;
  div_sts_t             div_sts;
  logic [TIME_BITS-1:0] div_dividend;
  logic [15:0]          div_divisor;
  logic [TIME_BITS-1:0] div_quot;
  logic [15:0]          div_rem;

  // Register file
  spr_anim_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Effective configuration
  assign cols_eff   = clamp_grid(cfg.grid_cols);
  assign rows_eff   = clamp_grid(cfg.grid_rows);
  assign tiles      = 10'(cols_eff) * 10'(rows_eff);
  assign period_eff = (cfg.frame_period == 16'd0) ? 16'd1 : cfg.frame_period;

  always_comb begin
    if (cfg.anim_length == 7'd0) begin
      len_eff = 7'd1;
    end else if (32'(cfg.anim_length) > MAX_FRAMES) begin
      len_eff = 7'(MAX_FRAMES);
    end else begin
      len_eff = cfg.anim_length;
    end
  end

  assign pos_inc  = 8'(pos_q) + 8'd1;
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign cmd      = cmd_e'(cmd_i);
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // Divider operand select
  always_comb begin
    div_ctl.start = go_q;
    case (state_q)
      S_TDIV: begin
        div_ctl.short_op = 1'b0;
        div_dividend     = diff_q;
        div_divisor      = period_eff;
      end
      S_POS: begin
        div_ctl.short_op = 1'b1;
        div_dividend     = TIME_BITS'(pos_inc);
        div_divisor      = 16'(len_eff);
      end
      S_TILE: begin
        div_ctl.short_op = 1'b1;
        div_dividend     = TIME_BITS'(rd_data_q);
        div_divisor      = 16'(tiles);
      end
      default: begin
        div_ctl.short_op = 1'b1;
        div_dividend     = TIME_BITS'(cur_frame_q);
        div_divisor      = 16'(cols_eff);
      end
    endcase
  end

  spr_anim_div #(
    .DW (TIME_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd)
            CMD_RESTART: state_d = S_RD;
            CMD_TIME:    state_d = S_CMP;
            default:     state_d = S_COLS;
          endcase
        end
      end
      S_CMP:  state_d = (CW'(diff_q) > CW'(period_eff)) ? S_TDIV : S_COLS;
      S_TDIV: if (div_sts.done) state_d = S_POS;
      S_POS:  if (div_sts.done) state_d = S_RD;
      S_RD:   state_d = S_TILE;
      S_TILE: if (div_sts.done) state_d = S_COLS;
      S_COLS: if (div_sts.done) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Start the divider on entry to a divide state
  assign go_d = (state_d != state_q) &&
                ((state_d == S_TDIV) || (state_d == S_POS) ||
                 (state_d == S_TILE) || (state_d == S_COLS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      go_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
    end
  end

  // Animation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      last_q      <= '0;
      cur_frame_q <= 8'd0;
    end else begin
      if (in_acc && (cmd == CMD_RESTART)) begin
        pos_q <= '0;
      end
      if ((state_q == S_TDIV) && div_sts.done) begin
        // advance by whole periods: now minus the leftover
        last_q <= now_q - TIME_BITS'(div_rem);
      end
      if ((state_q == S_POS) && div_sts.done) begin
        pos_q <= PW'(div_rem);
      end
      if ((state_q == S_TILE) && div_sts.done) begin
        cur_frame_q <= div_rem[7:0];
      end
    end
  end

  // Per-item working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q  <= TIME_BITS'(current_time_i);
      diff_q <= TIME_BITS'(current_time_i) - last_q;
      adv_q  <= (cmd == CMD_RESTART);
    end
    if ((state_q == S_TDIV) && div_sts.done) begin
      adv_q <= 1'b1;
    end
    if ((state_q == S_COLS) && div_sts.done) begin
      col_q <= div_rem[3:0];
      row_q <= div_quot[3:0];
    end
  end

  // Frame table: write on a load beat, registered read
  always_ff @(posedge clk_i) begin
    if (in_acc && (cmd == CMD_LOAD) && (32'(entry_index_i) < MAX_FRAMES)) begin
      frame_table[PW'(entry_index_i)] <= entry_frame_i;
    end
    if (state_q == S_RD) begin
      rd_data_q <= frame_table[pos_q];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_frame_q <= cur_frame_q;
      out_col_q   <= col_q;
      out_row_q   <= row_q;
      out_adv_q   <= adv_q;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign shown_frame_o = out_frame_q;
  assign tile_col_o    = out_col_q;
  assign tile_row_o    = out_row_q;
  assign advanced_o    = out_adv_q;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("sequencer took a beat without leaving idle");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_POS) && div_sts.done) |=> (7'(pos_q) < len_eff))
    else $error("play position not below animation length");

  a_frame_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_TILE) && div_sts.done) |=> ({2'b00, cur_frame_q} < tiles))
    else $error("shown frame not reduced modulo tile count");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none

module tb;
  import spr_anim_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned HOLD_PHASE   = 6;
  localparam int unsigned PAUSE_PHASE  = 3;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 80;
  localparam int unsigned LIMIT_CYCLES = 2000000;
  // cmd value with no meaning; the block must pass it through untouched
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  index;
    logic [7:0]  frame;
    logic [31:0] stamp;
  } anim_in_t;

  typedef struct packed {
    logic [7:0] shown;
    logic [3:0] col;
    logic [3:0] row;
    logic       adv;
  } anim_out_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e kind;
    anim_in_t  it;
    reg_idx_e  rsel;
    logic [31:0] value;
    bit        typed;
    anim_out_t want;
  } script_row_t;

  // DUT ports
  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  cmd_i;
  logic [5:0]  entry_index_i;
  logic [7:0]  entry_frame_i;
  logic [31:0] current_time_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  shown_frame_o;
  logic [3:0]  tile_col_o;
  logic [3:0]  tile_row_o;
  logic        advanced_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sprite_animation_sequencer_core DUT (.*);

  // Predictor state: table, play position, advance time, shown frame
  logic [7:0]  sheet_frames [TABLE_DEPTH];
  bit          frame_loaded [TABLE_DEPTH];
  logic [5:0]  play_pos   = '0;
  logic [31:0] adv_stamp  = '0;
  logic [7:0]  on_screen  = '0;
  // Predictor copy of the registers
  logic [4:0]  cols_r     = 5'd1;
  logic [4:0]  rows_r     = 5'd1;
  logic [6:0]  len_r      = 7'd1;
  logic [15:0] period_r   = 16'd1;

  anim_out_t   pending_frames [$];
  script_row_t script [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned advances_seen = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count   = 0;

  // Sheet dimension as the datapath uses it
  function automatic int unsigned sheet_dim(input logic [4:0] v);
    if (v == 5'd0) return 1;
    if (v > 5'd16) return 16;
    return 32'(v);
  endfunction

  function automatic int unsigned anim_len();
    if (len_r == 7'd0) return 1;
    if (len_r > 7'(TABLE_DEPTH)) return TABLE_DEPTH;
    return 32'(len_r);
  endfunction

  function automatic logic [31:0] eff_period();
    return (period_r == 16'd0) ? 32'd1 : 32'(period_r);
  endfunction

  // Apply one item to the predicted state and return the result it yields
  function automatic anim_out_t advance_sprite(input anim_in_t it);
    anim_out_t   res;
    logic [31:0] per;
    logic [31:0] gap;
    int unsigned cols;
    int unsigned tiles;
    res.adv = 1'b0;
    per = eff_period();
    tiles = sheet_dim(cols_r) * sheet_dim(rows_r);
    case (it.op)
      CMD_LOAD: begin
        sheet_frames[it.index] = it.frame;
        frame_loaded[it.index] = 1'b1;
      end
      CMD_RESTART: begin
        play_pos = '0;
        on_screen = 8'(int'(sheet_frames[0]) % tiles);
        res.adv = 1'b1;
      end
      CMD_TIME: begin
        gap = it.stamp - adv_stamp;
        if (gap > per) begin
          adv_stamp = adv_stamp + per * (gap / per);
          play_pos = 6'((int'(play_pos) + 1) % anim_len());
          on_screen = 8'(int'(sheet_frames[play_pos]) % tiles);
          res.adv = 1'b1;
        end
      end
      default: ;
    endcase
    cols = sheet_dim(cols_r);
    res.shown = on_screen;
    res.col = 4'(int'(on_screen) % cols);
    res.row = 4'(int'(on_screen) / cols);
    return res;
  endfunction

  // Random item, steered so that no unloaded table entry is ever shown
  function automatic anim_in_t pick_item();
    anim_in_t    it;
    logic [31:0] per;
    logic [31:0] gap;
    int unsigned roll;
    int unsigned nxt;
    roll = $urandom_range(99);
    per = eff_period();
    it.index = 6'($urandom);
    it.frame = 8'($urandom);
    it.stamp = $urandom;
    if (roll < 25) begin
      it.op = CMD_LOAD;
    end else if (roll < 32) begin
      it.op = CMD_RESTART;
    end else if (roll < 36) begin
      it.op = CMD_UNUSED;
    end else begin
      it.op = CMD_TIME;
      case ($urandom_range(5))
        0: it.stamp = adv_stamp + $urandom_range(per);
        1: it.stamp = adv_stamp + per;
        2: it.stamp = adv_stamp + per + 32'd1;
        3: it.stamp = adv_stamp + per * $urandom_range(2, 9) + $urandom_range(per - 32'd1);
        4: it.stamp = adv_stamp - $urandom_range(4);
        default: ;
      endcase
    end
    if (it.op == CMD_RESTART && !frame_loaded[0]) begin
      it.op = CMD_LOAD;
      it.index = 6'd0;
    end
    if (it.op == CMD_TIME) begin
      gap = it.stamp - adv_stamp;
      nxt = (int'(play_pos) + 1) % anim_len();
      if (gap > per && !frame_loaded[nxt]) begin
        it.op = CMD_LOAD;
        it.index = 6'(nxt);
      end
    end
    return it;
  endfunction

  function automatic logic [31:0] grid_pick();
    if ($urandom_range(9) == 0) return $urandom_range(31);
    return $urandom_range(1, 16);
  endfunction

  function automatic void row_item(input logic [1:0] op, input logic [5:0] idx,
                                   input logic [7:0] frm, input logic [31:0] stamp,
                                   input bit typed, input anim_out_t want);
    script_row_t r;
    r.kind = ROW_ITEM;
    r.it = {op, idx, frm, stamp};
    r.rsel = REG_GRID_COLS;
    r.value = '0;
    r.typed = typed;
    r.want = want;
    script.insert(script.size(), r);
  endfunction

  function automatic void row_reg(input reg_idx_e rsel, input logic [31:0] value);
    script_row_t r;
    r.kind = ROW_REG;
    r.it = '0;
    r.rsel = rsel;
    r.value = value;
    r.typed = 1'b0;
    r.want = '0;
    script.insert(script.size(), r);
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one beat; returns right after the edge that takes it
  task automatic send_item(input anim_in_t it, input bit typed, input anim_out_t want);
    anim_out_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= it.op;
    entry_index_i <= it.index;
    entry_frame_i <= it.frame;
    current_time_i <= it.stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = advance_sprite(it);
    pending_frames.insert(pending_frames.size(), typed ? want : res);
    items_sent++;
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
  endtask

  // Register write followed by a readback of the same register
  task automatic reg_write(input reg_idx_e rsel, input logic [31:0] v);
    logic [31:0] held;
    held = '0;
    case (rsel)
      REG_GRID_COLS:    begin cols_r = v[4:0];    held = 32'(v[4:0]);  end
      REG_GRID_ROWS:    begin rows_r = v[4:0];    held = 32'(v[4:0]);  end
      REG_ANIM_LENGTH:  begin len_r = v[6:0];     held = 32'(v[6:0]);  end
      REG_FRAME_PERIOD: begin period_r = v[15:0]; held = 32'(v[15:0]); end
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {rsel, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== held) begin
      $error("%s readback: expected %0d, got %0d", rsel.name(), held, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random stall, plus a long hold-off when asked for
  initial begin : result_taker
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    anim_out_t want;
    bit        bad;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (advanced_o) advances_seen++;
      if (pending_frames.size() == 0) begin
        $error("result beat with no prediction pending");
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        bad = 1'b0;
        if (shown_frame_o !== want.shown) begin
          $error("shown_frame: expected %0d, got %0d", want.shown, shown_frame_o);
          bad = 1'b1;
        end
        if (tile_col_o !== want.col) begin
          $error("tile_col: expected %0d, got %0d", want.col, tile_col_o);
          bad = 1'b1;
        end
        if (tile_row_o !== want.row) begin
          $error("tile_row: expected %0d, got %0d", want.row, tile_row_o);
          bad = 1'b1;
        end
        if (advanced_o !== want.adv) begin
          $error("advanced: expected %0d, got %0d", want.adv, advanced_o);
          bad = 1'b1;
        end
        if (bad) mismatches++;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    logic [31:0] g_cols;
    logic [31:0] g_rows;
    logic [31:0] a_len;
    logic [31:0] f_per;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = CMD_LOAD;
    entry_index_i = '0;
    entry_frame_i = '0;
    current_time_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset state, 1x1 sheet, time wrap, period boundary
    row_item(CMD_TIME,    6'd0,  8'd0,   32'd0,          1'b1, {8'd0, 4'd0, 4'd0, 1'b0});
    row_item(CMD_LOAD,    6'd0,  8'd255, 32'd0,          1'b1, {8'd0, 4'd0, 4'd0, 1'b0});
    row_item(CMD_UNUSED,  6'd63, 8'd0,   32'hFFFF_FFFF,  1'b1, {8'd0, 4'd0, 4'd0, 1'b0});
    row_item(CMD_RESTART, 6'd0,  8'd0,   32'd0,          1'b1, {8'd0, 4'd0, 4'd0, 1'b1});
    row_item(CMD_TIME,    6'd0,  8'd0,   32'd1,          1'b1, {8'd0, 4'd0, 4'd0, 1'b0});
    row_item(CMD_TIME,    6'd0,  8'd0,   32'd2,          1'b1, {8'd0, 4'd0, 4'd0, 1'b1});
    row_item(CMD_TIME,    6'd0,  8'd0,   32'hFFFF_FFFF,  1'b1, {8'd0, 4'd0, 4'd0, 1'b1});
    row_item(CMD_TIME,    6'd0,  8'd0,   32'd0,          1'b1, {8'd0, 4'd0, 4'd0, 1'b0});
    // Largest sheet, longest animation and period
    row_reg(REG_GRID_COLS, 32'd16);
    row_reg(REG_GRID_ROWS, 32'd16);
    row_reg(REG_ANIM_LENGTH, 32'd64);
    row_reg(REG_FRAME_PERIOD, 32'd65535);
    row_item(CMD_RESTART, 6'd0,  8'd0,   32'd0,          1'b1, {8'd255, 4'd15, 4'd15, 1'b1});
    row_item(CMD_LOAD,    6'd1,  8'h5A,  32'd0,          1'b1, {8'd255, 4'd15, 4'd15, 1'b0});
    row_item(CMD_LOAD,    6'd63, 8'hC3,  32'd0,          1'b1, {8'd255, 4'd15, 4'd15, 1'b0});
    row_item(CMD_TIME,    6'd0,  8'd0,   32'd65534,      1'b1, {8'd255, 4'd15, 4'd15, 1'b0});
    row_item(CMD_TIME,    6'd0,  8'd0,   32'd65535,      1'b0, '0);
    // Out-of-range registers; position now beyond the shortened length
    row_reg(REG_ANIM_LENGTH, 32'd0);
    row_reg(REG_GRID_COLS, 32'd0);
    row_reg(REG_GRID_ROWS, 32'd31);
    row_reg(REG_FRAME_PERIOD, 32'd0);
    row_item(CMD_TIME,    6'd0,  8'd0,   32'd65537,      1'b0, '0);
    row_item(CMD_TIME,    6'd0,  8'd0,   32'd65537,      1'b0, '0);
    row_item(CMD_RESTART, 6'd0,  8'd0,   32'd0,          1'b0, '0);
    // Odd sheet shape
    row_reg(REG_GRID_COLS, 32'd3);
    row_reg(REG_GRID_ROWS, 32'd5);
    row_reg(REG_ANIM_LENGTH, 32'd2);
    row_reg(REG_FRAME_PERIOD, 32'd7);
    row_item(CMD_LOAD,    6'd0,  8'd0,   32'd0,          1'b0, '0);
    row_item(CMD_RESTART, 6'd0,  8'd0,   32'd0,          1'b0, '0);
    row_item(CMD_TIME,    6'd0,  8'd0,   32'd65545,      1'b0, '0);
    row_item(CMD_TIME,    6'd0,  8'd0,   32'd65745,      1'b0, '0);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        drain_results();
        reg_write(script[i].rsel, script[i].value);
      end else begin
        send_item(script[i].it, script[i].typed, script[i].want);
      end
    end
    settings_used = 4;

    // Random phases: three idle patterns, each over three register settings
    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph / 3)
        0: begin send_idle_pct = 23; recv_idle_pct = 86; end
        1: begin send_idle_pct = 86; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 0) begin
        g_cols = 32'd1; g_rows = 32'd1; a_len = 32'd1; f_per = 32'd1;
      end else if (ph == 1) begin
        g_cols = 32'd16; g_rows = 32'd16; a_len = 32'd64; f_per = 32'd65535;
      end else begin
        g_cols = grid_pick();
        g_rows = grid_pick();
        case ($urandom_range(19))
          0, 1, 2:     a_len = $urandom_range(127);
          3, 4, 5, 6,
          7, 8, 9:     a_len = $urandom_range(1, 64);
          default:     a_len = $urandom_range(1, 8);
        endcase
        case ($urandom_range(9))
          0:           f_per = $urandom_range(1) * 32'd65535;
          1, 2:        f_per = $urandom_range(1, 65535);
          3, 4, 5:     f_per = $urandom_range(1, 1000);
          default:     f_per = $urandom_range(1, 16);
        endcase
      end
      reg_write(REG_GRID_COLS, g_cols);
      reg_write(REG_GRID_ROWS, g_rows);
      reg_write(REG_ANIM_LENGTH, a_len);
      reg_write(REG_FRAME_PERIOD, f_per);
      settings_used++;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == HOLD_PHASE && n == 40) hold_req = 1'b1;
        if (ph == PAUSE_PHASE && n == 100) drain_results();
        send_item(pick_item(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d items under %0d register settings; checked %0d results, %0d of them advances.",
             items_sent, settings_used, results_seen, advances_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
design/spr_anim_pkg.sv
design/spr_anim_regs.sv
design/spr_anim_div.sv
design/sprite_animation_sequencer_core.sv
verif/tb.sv
